[hw/rtl/h2df_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2df_pkg
// Shared types, codes and the connection preface table for the deframer.
// ----------------------------------------------------------------------------
package h2df_pkg;

    localparam int PREFACE_LEN = 24;
    localparam int PRIO_LEN    = 5;
    localparam int HDR_LEN     = 9;

    localparam logic [23:0] MAX_FRAME_LEN_RESET = 24'd131063;

    // result kinds
    localparam logic [2:0] KIND_HDR_BLOCK = 3'd0;
    localparam logic [2:0] KIND_BODY      = 3'd1;
    localparam logic [2:0] KIND_END       = 3'd2;
    localparam logic [2:0] KIND_RESET     = 3'd3;
    localparam logic [2:0] KIND_OVERSIZE  = 3'd4;
    localparam logic [2:0] KIND_PAD_ERR   = 3'd5;

    // frame types
    localparam logic [7:0] FT_DATA         = 8'h00;
    localparam logic [7:0] FT_HEADERS      = 8'h01;
    localparam logic [7:0] FT_RST_STREAM   = 8'h03;
    localparam logic [7:0] FT_CONTINUATION = 8'h09;

    // flag bit positions
    localparam int FLAG_END_STREAM = 0;
    localparam int FLAG_PADDED     = 3;
    localparam int FLAG_PRIORITY   = 5;

    // configuration register indexes
    localparam logic REG_EXPECT_PREFACE = 1'b0;
    localparam logic REG_MAX_FRAME_LEN  = 1'b1;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_PADLEN = 6'b000010,
        PH_PRIO   = 6'b000100,
        PH_BODY   = 6'b001000,
        PH_PAD    = 6'b010000,
        PH_SKIP   = 6'b100000
    } phase_t;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_TAIL    = 5'b00010,
        ST_REPLAY  = 5'b00100,
        ST_REPLAY2 = 5'b01000,
        ST_FLUSH   = 5'b10000
    } ctrl_state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [30:0] stream_id;
        logic [7:0]  payload_byte;
    } result_t;

    typedef struct packed {
        logic accept;
        logic parse;
        logic use_in;
        logic out_r0;
        logic out_pend;
        logic pend_load;
        logic hold_push;
        logic hold_src_pend;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic       pre_consume;
        logic       pre_replay;
        logic [1:0] res_cnt;
        logic       rep_final;
        logic       rep_over;
        logic       out_free;
        logic       hold_valid;
    } status_t;

    function automatic logic [7:0] preface_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'h50;
            5'd1:    b = 8'h52;
            5'd2:    b = 8'h49;
            5'd3:    b = 8'h20;
            5'd4:    b = 8'h2a;
            5'd5:    b = 8'h20;
            5'd6:    b = 8'h48;
            5'd7:    b = 8'h54;
            5'd8:    b = 8'h54;
            5'd9:    b = 8'h50;
            5'd10:   b = 8'h2f;
            5'd11:   b = 8'h32;
            5'd12:   b = 8'h2e;
            5'd13:   b = 8'h30;
            5'd14:   b = 8'h0d;
            5'd15:   b = 8'h0a;
            5'd16:   b = 8'h0d;
            5'd17:   b = 8'h0a;
            5'd18:   b = 8'h53;
            5'd19:   b = 8'h4d;
            5'd20:   b = 8'h0d;
            5'd21:   b = 8'h0a;
            5'd22:   b = 8'h0d;
            5'd23:   b = 8'h0a;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/h2df_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2df_datapath
// Config registers, preface matcher, frame parser state, replay source,
// and the pending, hold and output result registers.
// ----------------------------------------------------------------------------
module h2df_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic [7:0]          s_tdata,
    input  h2df_pkg::cmd_t      cmd,
    output h2df_pkg::status_t   st,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [39:0]         m_tdata,   // stream_id, payload_byte, zero pad
    output logic [2:0]          m_tuser,   // kind
    output logic                m_tlast
);

    logic              expect_reg;
    logic [23:0]       max_len_reg;

    h2df_pkg::phase_t  phase_reg, phase_next;
    logic [3:0]        hcnt_reg, hcnt_next;
    logic [23:0]       flen_reg, flen_next;
    logic [7:0]        fkind_reg, fkind_next;
    logic [7:0]        fflags_reg, fflags_next;
    logic [30:0]       sid_reg, sid_next;
    logic [23:0]       bleft_reg, bleft_next;
    logic [7:0]        pad_reg, pad_next;
    logic [2:0]        prio_reg, prio_next;

    logic [4:0]        pm_reg;
    logic              pdone_reg;
    logic [7:0]        byte_reg;
    logic [4:0]        idx_reg;
    logic [4:0]        rep_len_reg;

    h2df_pkg::result_t pend_reg;
    h2df_pkg::result_t hold_reg;
    logic              hold_valid_reg;
    h2df_pkg::result_t out_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    logic [7:0]        pb;
    logic              rep_final;
    logic              pre_match;
    logic              out_free;
    logic              out_load;

    logic [23:0]       fl_t;
    logic [30:0]       sid_t;
    logic [23:0]       bl1;
    logic              known_kind;
    logic              padded;
    logic              prio;
    logic [2:0]        need;
    logic              e_first;
    logic [2:0]        e_kind;
    logic [7:0]        e_byte;
    logic              e_end;
    h2df_pkg::result_t r0;
    h2df_pkg::result_t r1;

    function automatic h2df_pkg::phase_t np_phase(
        input logic [23:0] bl,
        input logic [2:0]  pr,
        input logic [7:0]  pd
    );
        h2df_pkg::phase_t p;
        if (bl == 24'd0)
            p = h2df_pkg::PH_HEADER;
        else if (pr != 3'd0)
            p = h2df_pkg::PH_PRIO;
        else if (bl > {16'd0, pd})
            p = h2df_pkg::PH_BODY;
        else
            p = h2df_pkg::PH_PAD;
        return p;
    endfunction

    function automatic logic end_ok(input logic [7:0] k, input logic [7:0] f);
        return f[h2df_pkg::FLAG_END_STREAM] &&
            (k == h2df_pkg::FT_DATA || k == h2df_pkg::FT_HEADERS ||
             k == h2df_pkg::FT_CONTINUATION);
    endfunction

    function automatic h2df_pkg::phase_t skip_phase(input logic [23:0] n);
        return (n != 24'd0) ? h2df_pkg::PH_SKIP : h2df_pkg::PH_HEADER;
    endfunction

    // byte source and preface match
    assign rep_final = (idx_reg == rep_len_reg);
    assign pb        = cmd.use_in ? s_tdata :
                       (rep_final ? byte_reg : h2df_pkg::preface_byte(idx_reg));
    assign pre_match = expect_reg && (s_tdata == h2df_pkg::preface_byte(pm_reg));
    assign out_free  = !out_valid_reg || m_tready;

    // frame parser, one byte
    always_comb
    begin
        phase_next  = phase_reg;
        hcnt_next   = hcnt_reg;
        flen_next   = flen_reg;
        fkind_next  = fkind_reg;
        fflags_next = fflags_reg;
        sid_next    = sid_reg;
        bleft_next  = bleft_reg;
        pad_next    = pad_reg;
        prio_next   = prio_reg;
        e_first     = 1'b0;
        e_kind      = h2df_pkg::KIND_HDR_BLOCK;
        e_byte      = 8'd0;
        e_end       = 1'b0;
        fl_t        = flen_reg;
        sid_t       = sid_reg;
        bl1         = bleft_reg - 24'd1;
        known_kind  = 1'b0;
        padded      = 1'b0;
        prio        = 1'b0;
        need        = 3'd0;
        case (phase_reg)
            h2df_pkg::PH_HEADER:
            begin
                if (hcnt_reg == 4'd0)
                begin
                    fl_t  = 24'd0;
                    sid_t = 31'd0;
                end
                flen_next = fl_t;
                sid_next  = sid_t;
                if (hcnt_reg < 4'd3)
                    flen_next = {fl_t[15:0], pb};
                if (hcnt_reg == 4'd3)
                    fkind_next = pb;
                if (hcnt_reg == 4'd4)
                    fflags_next = pb;
                if (hcnt_reg == 4'd5)
                    sid_next = {24'd0, pb[6:0]};
                else if (hcnt_reg > 4'd5)
                    sid_next = {sid_t[22:0], pb};
                if (hcnt_reg != 4'(h2df_pkg::HDR_LEN - 1))
                    hcnt_next = hcnt_reg + 4'd1;
                else
                begin
                    hcnt_next  = 4'd0;
                    known_kind = (fkind_next == h2df_pkg::FT_DATA) ||
                                 (fkind_next == h2df_pkg::FT_HEADERS) ||
                                 (fkind_next == h2df_pkg::FT_RST_STREAM) ||
                                 (fkind_next == h2df_pkg::FT_CONTINUATION);
                    padded = ((fkind_next == h2df_pkg::FT_DATA) ||
                              (fkind_next == h2df_pkg::FT_HEADERS)) &&
                             fflags_next[h2df_pkg::FLAG_PADDED];
                    prio   = (fkind_next == h2df_pkg::FT_HEADERS) &&
                             fflags_next[h2df_pkg::FLAG_PRIORITY];
                    need   = {2'd0, padded} + (prio ? 3'(h2df_pkg::PRIO_LEN) : 3'd0);
                    bleft_next = flen_next;
                    pad_next   = 8'd0;
                    prio_next  = 3'd0;
                    if (flen_next > max_len_reg)
                    begin
                        e_first    = 1'b1;
                        e_kind     = h2df_pkg::KIND_OVERSIZE;
                        phase_next = skip_phase(flen_next);
                    end
                    else if (sid_next == 31'd0 || !known_kind)
                        phase_next = skip_phase(flen_next);
                    else if (fkind_next == h2df_pkg::FT_RST_STREAM)
                    begin
                        e_first    = 1'b1;
                        e_kind     = h2df_pkg::KIND_RESET;
                        phase_next = skip_phase(flen_next);
                    end
                    else if (flen_next < {21'd0, need})
                    begin
                        e_first    = 1'b1;
                        e_kind     = h2df_pkg::KIND_PAD_ERR;
                        phase_next = skip_phase(flen_next);
                    end
                    else
                    begin
                        prio_next = prio ? 3'(h2df_pkg::PRIO_LEN) : 3'd0;
                        if (flen_next == 24'd0)
                        begin
                            e_end      = end_ok(fkind_next, fflags_next);
                            phase_next = h2df_pkg::PH_HEADER;
                        end
                        else if (padded)
                            phase_next = h2df_pkg::PH_PADLEN;
                        else
                            phase_next = np_phase(flen_next, prio_next, 8'd0);
                    end
                end
            end
            h2df_pkg::PH_PADLEN:
            begin
                bleft_next = bl1;
                if ({16'd0, pb} > (bl1 - {21'd0, prio_reg}))
                begin
                    e_first    = 1'b1;
                    e_kind     = h2df_pkg::KIND_PAD_ERR;
                    pad_next   = 8'd0;
                    prio_next  = 3'd0;
                    phase_next = skip_phase(bl1);
                end
                else
                begin
                    pad_next   = pb;
                    phase_next = np_phase(bl1, prio_reg, pb);
                    e_end      = (bl1 == 24'd0) && end_ok(fkind_reg, fflags_reg);
                end
            end
            h2df_pkg::PH_PRIO:
            begin
                bleft_next = bl1;
                prio_next  = prio_reg - 3'd1;
                phase_next = np_phase(bl1, prio_next, pad_reg);
                e_end      = (bl1 == 24'd0) && end_ok(fkind_reg, fflags_reg);
            end
            h2df_pkg::PH_BODY:
            begin
                bleft_next = bl1;
                e_first    = 1'b1;
                e_kind     = (fkind_reg == h2df_pkg::FT_DATA) ?
                             h2df_pkg::KIND_BODY : h2df_pkg::KIND_HDR_BLOCK;
                e_byte     = pb;
                phase_next = np_phase(bl1, prio_reg, pad_reg);
                e_end      = (bl1 == 24'd0) && end_ok(fkind_reg, fflags_reg);
            end
            h2df_pkg::PH_PAD:
            begin
                bleft_next = bl1;
                pad_next   = (pad_reg != 8'd0) ? pad_reg - 8'd1 : 8'd0;
                phase_next = np_phase(bl1, prio_reg, pad_next);
                e_end      = (bl1 == 24'd0) && end_ok(fkind_reg, fflags_reg);
            end
            h2df_pkg::PH_SKIP:
            begin
                bleft_next = (bleft_reg != 24'd0) ? bl1 : 24'd0;
                if (bleft_next == 24'd0)
                    phase_next = h2df_pkg::PH_HEADER;
            end
            default:
            begin
                phase_next = h2df_pkg::PH_HEADER;
            end
        endcase
    end

    assign r0 = e_first ? '{kind: e_kind, stream_id: sid_next, payload_byte: e_byte} :
                          '{kind: h2df_pkg::KIND_END, stream_id: sid_next, payload_byte: 8'd0};
    assign r1 = '{kind: h2df_pkg::KIND_END, stream_id: sid_next, payload_byte: 8'd0};

    assign st.pre_consume = !pdone_reg && pre_match;
    assign st.pre_replay  = !pdone_reg && !pre_match && (pm_reg != 5'd0);
    assign st.res_cnt     = {1'b0, e_first} + {1'b0, e_end};
    assign st.rep_final   = rep_final;
    assign st.rep_over    = (idx_reg > rep_len_reg);
    assign st.out_free    = out_free;
    assign st.hold_valid  = hold_valid_reg;

    assign out_load = cmd.out_r0 || cmd.out_pend || cmd.flush ||
                      (cmd.hold_push && hold_valid_reg);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_reg  <= 1'b1;
            max_len_reg <= h2df_pkg::MAX_FRAME_LEN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                h2df_pkg::REG_EXPECT_PREFACE: expect_reg  <= cfg_data[0];
                h2df_pkg::REG_MAX_FRAME_LEN:  max_len_reg <= cfg_data;
                default:                      expect_reg  <= expect_reg;
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= h2df_pkg::PH_HEADER;
            hcnt_reg   <= 4'd0;
            flen_reg   <= 24'd0;
            fkind_reg  <= 8'd0;
            fflags_reg <= 8'd0;
            sid_reg    <= 31'd0;
            bleft_reg  <= 24'd0;
            pad_reg    <= 8'd0;
            prio_reg   <= 3'd0;
        end
        else if (cmd.parse)
        begin
            phase_reg  <= phase_next;
            hcnt_reg   <= hcnt_next;
            flen_reg   <= flen_next;
            fkind_reg  <= fkind_next;
            fflags_reg <= fflags_next;
            sid_reg    <= sid_next;
            bleft_reg  <= bleft_next;
            pad_reg    <= pad_next;
            prio_reg   <= prio_next;
        end
    end

    // preface matcher and replay source
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_reg      <= 5'd0;
            pdone_reg   <= 1'b0;
            idx_reg     <= 5'd0;
            rep_len_reg <= 5'd0;
        end
        else
        begin
            if (cmd.accept && !pdone_reg)
            begin
                if (pre_match)
                begin
                    if (pm_reg == 5'(h2df_pkg::PREFACE_LEN - 1))
                    begin
                        pdone_reg <= 1'b1;
                        pm_reg    <= 5'd0;
                    end
                    else
                        pm_reg <= pm_reg + 5'd1;
                end
                else
                begin
                    pdone_reg   <= 1'b1;
                    pm_reg      <= 5'd0;
                    rep_len_reg <= pm_reg;
                    idx_reg     <= 5'd0;
                end
            end
            else if (cmd.parse && !cmd.use_in)
                idx_reg <= idx_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            byte_reg <= s_tdata;
        if (cmd.pend_load)
            pend_reg <= r1;
        if (cmd.hold_push)
            hold_reg <= cmd.hold_src_pend ? pend_reg : r0;
        if (cmd.out_r0)
        begin
            out_reg      <= r0;
            out_last_reg <= (st.res_cnt == 2'd1);
        end
        else if (cmd.out_pend)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= 1'b1;
        end
        else if (cmd.flush)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= 1'b1;
        end
        else if (cmd.hold_push && hold_valid_reg)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.hold_push)
                hold_valid_reg <= 1'b1;
            else if (cmd.flush)
                hold_valid_reg <= 1'b0;
            out_valid_reg <= out_load || (out_valid_reg && !m_tready);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.payload_byte, out_reg.stream_id};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;

endmodule

[hw/rtl/h2df_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2df_ctrl
// Sequencer: direct byte parsing, preface replay, and result ordering.
// ----------------------------------------------------------------------------
module h2df_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  h2df_pkg::status_t   st,
    output h2df_pkg::cmd_t      cmd
);

    h2df_pkg::ctrl_state_t state_reg, state_next;
    logic                  can_push;

    assign can_push = !st.hold_valid || st.out_free;
    assign s_tready = (state_reg == h2df_pkg::ST_IDLE) && st.out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.use_in = (state_reg == h2df_pkg::ST_IDLE);
        case (state_reg)
            h2df_pkg::ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd.accept = 1'b1;
                    if (st.pre_replay)
                        state_next = h2df_pkg::ST_REPLAY;
                    else if (!st.pre_consume)
                    begin
                        cmd.parse  = 1'b1;
                        cmd.out_r0 = (st.res_cnt != 2'd0);
                        if (st.res_cnt == 2'd2)
                        begin
                            cmd.pend_load = 1'b1;
                            state_next    = h2df_pkg::ST_TAIL;
                        end
                    end
                end
            end
            h2df_pkg::ST_TAIL:
            begin
                if (st.out_free)
                begin
                    cmd.out_pend = 1'b1;
                    state_next   = h2df_pkg::ST_IDLE;
                end
            end
            h2df_pkg::ST_REPLAY:
            begin
                if (can_push)
                begin
                    cmd.parse     = 1'b1;
                    cmd.hold_push = (st.res_cnt != 2'd0);
                    if (st.res_cnt == 2'd2)
                    begin
                        cmd.pend_load = 1'b1;
                        state_next    = h2df_pkg::ST_REPLAY2;
                    end
                    else if (st.rep_final)
                        state_next = h2df_pkg::ST_FLUSH;
                end
            end
            h2df_pkg::ST_REPLAY2:
            begin
                if (can_push)
                begin
                    cmd.hold_push     = 1'b1;
                    cmd.hold_src_pend = 1'b1;
                    state_next        = st.rep_over ? h2df_pkg::ST_FLUSH
                                                    : h2df_pkg::ST_REPLAY;
                end
            end
            h2df_pkg::ST_FLUSH:
            begin
                if (!st.hold_valid)
                    state_next = h2df_pkg::ST_IDLE;
                else if (st.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = h2df_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = h2df_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= h2df_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // hold slot always drained before a new request is taken
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == h2df_pkg::ST_IDLE) |-> !st.hold_valid)
        else $error("hold slot occupied while idle");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !st.out_free |-> !(cmd.out_r0 || cmd.out_pend || cmd.flush ||
                           (cmd.hold_push && st.hold_valid)))
        else $error("output register overwritten while stalled");

    // replay never runs past the held input byte
    a_replay_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == h2df_pkg::ST_REPLAY) |-> !st.rep_over)
        else $error("replay index beyond held byte");

    // two results per parsed byte only from the body byte path; tail is entered from idle, not replay
    a_tail_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == h2df_pkg::ST_TAIL) |-> $past(state_reg) == h2df_pkg::ST_IDLE ||
                                             $past(state_reg) == h2df_pkg::ST_TAIL)
        else $error("tail state entered from replay");

endmodule

[hw/rtl/http2_frame_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http2_frame_deframer
// HTTP/2 byte stream deframer: strips the client preface, parses frame
// headers and passes header-block and body bytes with stream events.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            contents
//  s_*       in   s_tvalid/s_tready    tdata: raw connection byte
//  m_*       out  m_tvalid/m_tready    tdata: stream_id, payload_byte; tuser: kind
//  cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  one byte per cycle while the output register is free; a byte that yields
//  a content byte plus stream end sends the stream end after it through the
//  single output register; a preface mismatch replays the held preface bytes
//  through the parser, one per cycle while the output can take results
//  reset restores config defaults and re-arms the preface check
//  m_tready low holds the output register and stops input acceptance
// ----------------------------------------------------------------------------
module http2_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // stream_id[30:0], payload_byte[38:31], zero
    output logic [2:0]  m_tuser,    // kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data
);

    h2df_pkg::cmd_t    cmd;
    h2df_pkg::status_t st;

    assign cfg_ready = 1'b1;

    h2df_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    h2df_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .st        (st),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
